// ===== design/assert_macros.svh =====
// Assertion helpers used by the top-level parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/sbnep_pkg.sv =====
package sbnep_pkg;

    typedef enum logic [2:0] {
        EV_NOTE_ON  = 3'd0,
        EV_NOTE_OFF = 3'd1,
        EV_DELAY    = 3'd2,
        EV_REWIND   = 3'd3,
        EV_HALT     = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_CMD   = 2'd0,
        PH_DLO   = 2'd1,
        PH_NOTE  = 2'd2,
        PH_VEL   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_OUT  = 2'd2
    } back_state_t;

    localparam logic [1:0] REG_TEMPO     = 2'd0;
    localparam logic [1:0] REG_TRANSPOSE = 2'd1;
    localparam logic [1:0] REG_REPEAT    = 2'd2;

    localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
    localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CMD_REWIND    = 4'hE;
    localparam logic [3:0] CMD_END_SCORE = 4'hF;

    // Classified work item handed from the front to the back.
    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [14:0] ticks;
    } work_t;

    function automatic logic [21:0] freq_lookup(input logic [6:0] n);
        logic [21:0] f;
        begin
            unique case (n)
                7'd0: f = 22'd2093; 7'd1: f = 22'd2217; 7'd2: f = 22'd2349;
                7'd3: f = 22'd2489; 7'd4: f = 22'd2637; 7'd5: f = 22'd2794;
                7'd6: f = 22'd2960; 7'd7: f = 22'd3136; 7'd8: f = 22'd3322;
                7'd9: f = 22'd3520; 7'd10: f = 22'd3729; 7'd11: f = 22'd3951;
                7'd12: f = 22'd4186; 7'd13: f = 22'd4435; 7'd14: f = 22'd4699;
                7'd15: f = 22'd4978; 7'd16: f = 22'd5274; 7'd17: f = 22'd5588;
                7'd18: f = 22'd5920; 7'd19: f = 22'd6272; 7'd20: f = 22'd6645;
                7'd21: f = 22'd7040; 7'd22: f = 22'd7459; 7'd23: f = 22'd7902;
                7'd24: f = 22'd8372; 7'd25: f = 22'd8870; 7'd26: f = 22'd9397;
                7'd27: f = 22'd9956; 7'd28: f = 22'd10548; 7'd29: f = 22'd11175;
                7'd30: f = 22'd11840; 7'd31: f = 22'd12544; 7'd32: f = 22'd13290;
                7'd33: f = 22'd14080; 7'd34: f = 22'd14917; 7'd35: f = 22'd15804;
                7'd36: f = 22'd16744; 7'd37: f = 22'd17740; 7'd38: f = 22'd18795;
                7'd39: f = 22'd19912; 7'd40: f = 22'd21096; 7'd41: f = 22'd22351;
                7'd42: f = 22'd23680; 7'd43: f = 22'd25088; 7'd44: f = 22'd26580;
                7'd45: f = 22'd28160; 7'd46: f = 22'd29834; 7'd47: f = 22'd31609;
                7'd48: f = 22'd33488; 7'd49: f = 22'd35479; 7'd50: f = 22'd37589;
                7'd51: f = 22'd39824; 7'd52: f = 22'd42192; 7'd53: f = 22'd44701;
                7'd54: f = 22'd47359; 7'd55: f = 22'd50175; 7'd56: f = 22'd53159;
                7'd57: f = 22'd56320; 7'd58: f = 22'd59669; 7'd59: f = 22'd63217;
                7'd60: f = 22'd66976; 7'd61: f = 22'd70959; 7'd62: f = 22'd75178;
                7'd63: f = 22'd79649; 7'd64: f = 22'd84385; 7'd65: f = 22'd89402;
                7'd66: f = 22'd94719; 7'd67: f = 22'd100351; 7'd68: f = 22'd106318;
                7'd69: f = 22'd112640; 7'd70: f = 22'd119338; 7'd71: f = 22'd126434;
                7'd72: f = 22'd133952; 7'd73: f = 22'd141918; 7'd74: f = 22'd150356;
                7'd75: f = 22'd159297; 7'd76: f = 22'd168769; 7'd77: f = 22'd178805;
                7'd78: f = 22'd189437; 7'd79: f = 22'd200702; 7'd80: f = 22'd212636;
                7'd81: f = 22'd225280; 7'd82: f = 22'd238676; 7'd83: f = 22'd252868;
                7'd84: f = 22'd267905; 7'd85: f = 22'd283835; 7'd86: f = 22'd300713;
                7'd87: f = 22'd318594; 7'd88: f = 22'd337539; 7'd89: f = 22'd357610;
                7'd90: f = 22'd378874; 7'd91: f = 22'd401403; 7'd92: f = 22'd425272;
                7'd93: f = 22'd450560; 7'd94: f = 22'd477352; 7'd95: f = 22'd505736;
                7'd96: f = 22'd535809; 7'd97: f = 22'd567670; 7'd98: f = 22'd601425;
                7'd99: f = 22'd637188; 7'd100: f = 22'd675077; 7'd101: f = 22'd715219;
                7'd102: f = 22'd757749; 7'd103: f = 22'd802807; 7'd104: f = 22'd850544;
                7'd105: f = 22'd901120; 7'd106: f = 22'd954703; 7'd107: f = 22'd1011473;
                7'd108: f = 22'd1071618; 7'd109: f = 22'd1135340;
                7'd110: f = 22'd1202851; 7'd111: f = 22'd1274376;
                7'd112: f = 22'd1350154; 7'd113: f = 22'd1430439;
                7'd114: f = 22'd1515497; 7'd115: f = 22'd1605613;
                7'd116: f = 22'd1701088; 7'd117: f = 22'd1802240;
                7'd118: f = 22'd1909407; 7'd119: f = 22'd2022946;
                7'd120: f = 22'd2143237; 7'd121: f = 22'd2270680;
                7'd122: f = 22'd2405702; 7'd123: f = 22'd2548752;
                7'd124: f = 22'd2700309; 7'd125: f = 22'd2860878;
                7'd126: f = 22'd3030994;
                default: f = 22'd3211227;
            endcase
            return f;
        end
    endfunction

    // Index is the clamped velocity 1..127; index 0 is never used.
    function automatic logic [15:0] amp_lookup(input logic [6:0] v);
        logic [15:0] a;
        begin
            unique case (v)
                7'd1: a = 16'd583; 7'd2: a = 16'd644; 7'd3: a = 16'd709;
                7'd4: a = 16'd777; 7'd5: a = 16'd848; 7'd6: a = 16'd922;
                7'd7: a = 16'd999; 7'd8: a = 16'd1079; 7'd9: a = 16'd1163;
                7'd10: a = 16'd1249; 7'd11: a = 16'd1339; 7'd12: a = 16'd1432;
                7'd13: a = 16'd1527; 7'd14: a = 16'd1626; 7'd15: a = 16'd1728;
                7'd16: a = 16'd1833; 7'd17: a = 16'd1941; 7'd18: a = 16'd2053;
                7'd19: a = 16'd2167; 7'd20: a = 16'd2285; 7'd21: a = 16'd2405;
                7'd22: a = 16'd2529; 7'd23: a = 16'd2656; 7'd24: a = 16'd2785;
                7'd25: a = 16'd2918; 7'd26: a = 16'd3054; 7'd27: a = 16'd3194;
                7'd28: a = 16'd3336; 7'd29: a = 16'd3481; 7'd30: a = 16'd3630;
                7'd31: a = 16'd3781; 7'd32: a = 16'd3936; 7'd33: a = 16'd4094;
                7'd34: a = 16'd4255; 7'd35: a = 16'd4418; 7'd36: a = 16'd4586;
                7'd37: a = 16'd4756; 7'd38: a = 16'd4929; 7'd39: a = 16'd5106;
                7'd40: a = 16'd5285; 7'd41: a = 16'd5467; 7'd42: a = 16'd5653;
                7'd43: a = 16'd5842; 7'd44: a = 16'd6034; 7'd45: a = 16'd6229;
                7'd46: a = 16'd6427; 7'd47: a = 16'd6628; 7'd48: a = 16'd6832;
                7'd49: a = 16'd7040; 7'd50: a = 16'd7250; 7'd51: a = 16'd7464;
                7'd52: a = 16'd7680; 7'd53: a = 16'd7900; 7'd54: a = 16'd8123;
                7'd55: a = 16'd8349; 7'd56: a = 16'd8578; 7'd57: a = 16'd8810;
                7'd58: a = 16'd9046; 7'd59: a = 16'd9284; 7'd60: a = 16'd9526;
                7'd61: a = 16'd9770; 7'd62: a = 16'd10018; 7'd63: a = 16'd10269;
                7'd64: a = 16'd10522; 7'd65: a = 16'd10779; 7'd66: a = 16'd11040;
                7'd67: a = 16'd11303; 7'd68: a = 16'd11569; 7'd69: a = 16'd11838;
                7'd70: a = 16'd12111; 7'd71: a = 16'd12387; 7'd72: a = 16'd12665;
                7'd73: a = 16'd12947; 7'd74: a = 16'd13232; 7'd75: a = 16'd13520;
                7'd76: a = 16'd13811; 7'd77: a = 16'd14105; 7'd78: a = 16'd14403;
                7'd79: a = 16'd14703; 7'd80: a = 16'd15006; 7'd81: a = 16'd15313;
                7'd82: a = 16'd15623; 7'd83: a = 16'd15935; 7'd84: a = 16'd16251;
                7'd85: a = 16'd16570; 7'd86: a = 16'd16893; 7'd87: a = 16'd17218;
                7'd88: a = 16'd17546; 7'd89: a = 16'd17877; 7'd90: a = 16'd18212;
                7'd91: a = 16'd18550; 7'd92: a = 16'd18890; 7'd93: a = 16'd19234;
                7'd94: a = 16'd19581; 7'd95: a = 16'd19931; 7'd96: a = 16'd20284;
                7'd97: a = 16'd20640; 7'd98: a = 16'd20999; 7'd99: a = 16'd21362;
                7'd100: a = 16'd21727; 7'd101: a = 16'd22096; 7'd102: a = 16'd22468;
                7'd103: a = 16'd22843; 7'd104: a = 16'd23220; 7'd105: a = 16'd23601;
                7'd106: a = 16'd23986; 7'd107: a = 16'd24373; 7'd108: a = 16'd24763;
                7'd109: a = 16'd25156; 7'd110: a = 16'd25553; 7'd111: a = 16'd25953;
                7'd112: a = 16'd26355; 7'd113: a = 16'd26761; 7'd114: a = 16'd27170;
                7'd115: a = 16'd27582; 7'd116: a = 16'd27997; 7'd117: a = 16'd28415;
                7'd118: a = 16'd28837; 7'd119: a = 16'd29261; 7'd120: a = 16'd29688;
                7'd121: a = 16'd30119; 7'd122: a = 16'd30553; 7'd123: a = 16'd30990;
                7'd124: a = 16'd31430; 7'd125: a = 16'd31873; 7'd126: a = 16'd32319;
                7'd127: a = 16'd32768;
                default: a = 16'd583;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== design/score_bytestream_note_event_parser.sv =====
// Score byte parser: one score byte per input beat; note-on, note-off, delay, rewind and
// halt events leave one per output beat. Command and operand bytes are parsed into work
// items held in a two-entry queue; a note or control event then goes straight to the
// event builder's output register, while a delay first runs 23 steps of the bit-serial
// tempo divider, which sets the rate for delay-heavy scores.
`include "assert_macros.svh"

module score_bytestream_note_event_parser #(
    parameter int NUM_VOICES  = 16,
    parameter int PITCH_COUNT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_score_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [3:0]  m_voice_channel,
    output logic [6:0]  m_note_number,
    output logic [15:0] m_amplitude_level,
    output logic [21:0] m_frequency_hz,
    output logic [22:0] m_delay_ms
);

    logic [15:0] tempo_reg;
    logic [7:0]  transpose_reg;
    logic        repeat_reg;

    logic             push, q_full, q_valid, q_pop;
    sbnep_pkg::work_t push_item, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_reg     <= 16'd256;
            transpose_reg <= 8'd0;
            repeat_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sbnep_pkg::REG_TEMPO:     tempo_reg     <= cfg_data;
                sbnep_pkg::REG_TRANSPOSE: transpose_reg <= cfg_data[7:0];
                sbnep_pkg::REG_REPEAT:    repeat_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sbnep_front #(.NUM_VOICES(NUM_VOICES), .PITCH_COUNT(PITCH_COUNT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .byte_valid(s_valid), .byte_ready(s_ready), .score_byte(s_score_byte),
        .transpose(transpose_reg), .repeat_on(repeat_reg),
        .push(push), .push_item(push_item), .q_full(q_full)
    );

    sbnep_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .head(q_head)
    );

    sbnep_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop), .tempo(tempo_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_event_kind(m_event_kind), .m_voice_channel(m_voice_channel),
        .m_note_number(m_note_number), .m_amplitude_level(m_amplitude_level),
        .m_frequency_hz(m_frequency_hz), .m_delay_ms(m_delay_ms)
    );

    `ASSERT_CLK(a_no_push_full, aclk, aresetn, !(push && q_full), "push into full queue")
    `ASSERT_CLK(a_no_pop_empty, aclk, aresetn, !(q_pop && !q_valid), "pop from empty queue")
    `ASSERT_CLK(a_delay_nonzero, aclk, aresetn,
        !(m_valid && m_event_kind == sbnep_pkg::EV_DELAY && m_delay_ms == 23'd0),
        "zero delay delivered")

endmodule

// ===== design/sbnep_front.sv =====
// Score byte parser: tracks the operand phase and pushes one work item per event.
module sbnep_front #(
    parameter int NUM_VOICES  = 16,
    parameter int PITCH_COUNT = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        score_byte,
    input  logic [7:0]        transpose,
    input  logic              repeat_on,
    output logic              push,
    output sbnep_pkg::work_t  push_item,
    input  logic              q_full
);

    sbnep_pkg::phase_t phase_reg, phase_next;
    logic [6:0] dhi_reg, dhi_next;
    logic [3:0] chan_reg, chan_next;
    logic [7:0] note_reg, note_next;

    logic       take;
    logic [8:0] tnote;
    logic [6:0] vel;

    assign byte_ready = !q_full;
    assign take = byte_valid && byte_ready;
    assign tnote = {1'b0, note_reg} + {transpose[7], transpose};
    assign vel = (score_byte == 8'd0) ? 7'd1 :
                 score_byte[7] ? 7'd127 : score_byte[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sbnep_pkg::PH_CMD;
            dhi_reg   <= '0;
            chan_reg  <= '0;
            note_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            dhi_reg   <= dhi_next;
            chan_reg  <= chan_next;
            note_reg  <= note_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        dhi_next   = dhi_reg;
        chan_next  = chan_reg;
        note_next  = note_reg;
        push       = 1'b0;
        push_item  = '0;
        if (take) begin
            unique case (phase_reg)
                sbnep_pkg::PH_DLO: begin
                    phase_next = sbnep_pkg::PH_CMD;
                    push = 1'b1;
                    push_item.kind  = sbnep_pkg::EV_DELAY;
                    push_item.ticks = {dhi_reg, score_byte};
                end
                sbnep_pkg::PH_NOTE: begin
                    note_next  = score_byte;
                    phase_next = sbnep_pkg::PH_VEL;
                end
                sbnep_pkg::PH_VEL: begin
                    phase_next = sbnep_pkg::PH_CMD;
                    // The sum is signed 9 bits; bit 8 set means negative.
                    push = !tnote[8] && ({23'd0, tnote} < 32'(PITCH_COUNT))
                           && ({28'd0, chan_reg} < 32'(NUM_VOICES));
                    push_item.kind = sbnep_pkg::EV_NOTE_ON;
                    push_item.chan = chan_reg;
                    push_item.note = tnote[6:0];
                    push_item.vel  = vel;
                end
                default: begin
                    phase_next = sbnep_pkg::PH_CMD;
                    if (!score_byte[7]) begin
                        dhi_next   = score_byte[6:0];
                        phase_next = sbnep_pkg::PH_DLO;
                    end else begin
                        priority case (score_byte[7:4])
                            sbnep_pkg::CMD_NOTE_ON: begin
                                chan_next  = score_byte[3:0];
                                phase_next = sbnep_pkg::PH_NOTE;
                            end
                            sbnep_pkg::CMD_NOTE_OFF: begin
                                push = {28'd0, score_byte[3:0]} < 32'(NUM_VOICES);
                                push_item.kind = sbnep_pkg::EV_NOTE_OFF;
                                push_item.chan = score_byte[3:0];
                            end
                            sbnep_pkg::CMD_REWIND: begin
                                push = 1'b1;
                                push_item.kind = sbnep_pkg::EV_REWIND;
                            end
                            sbnep_pkg::CMD_END_SCORE: begin
                                push = 1'b1;
                                push_item.kind = repeat_on ? sbnep_pkg::EV_REWIND
                                                           : sbnep_pkg::EV_HALT;
                            end
                            default: push = 1'b0;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/sbnep_queue.sv =====
// Two-entry FIFO between the parser and the event builder.
module sbnep_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sbnep_pkg::work_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output sbnep_pkg::work_t  head
);

    sbnep_pkg::work_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/sbnep_back.sv =====
// Event builder: table lookups and a bit-serial tempo divider, then an output register.
module sbnep_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  sbnep_pkg::work_t  q_head,
    output logic              q_pop,
    input  logic [15:0]       tempo,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_event_kind,
    output logic [3:0]        m_voice_channel,
    output logic [6:0]        m_note_number,
    output logic [15:0]       m_amplitude_level,
    output logic [21:0]       m_frequency_hz,
    output logic [22:0]       m_delay_ms
);

    sbnep_pkg::back_state_t st_reg, st_next;
    logic [22:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] div_reg;
    logic        load, finish, hold;
    logic [16:0] trial;
    sbnep_pkg::work_t it;

    assign it = q_head;
    assign trial = {rem_reg, quo_reg[22]} - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= sbnep_pkg::BK_IDLE;
            m_valid <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (finish) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (load) begin
            div_reg <= (tempo == 16'd0) ? 16'd1 : tempo;
        end
    end

    // Non-delay events go straight to the output register; delays divide first.
    always_ff @(posedge aclk) begin
        if (load && it.kind != sbnep_pkg::EV_DELAY) begin
            m_event_kind      <= it.kind;
            m_voice_channel   <= it.chan;
            m_note_number     <= (it.kind == sbnep_pkg::EV_NOTE_ON) ? it.note : 7'd0;
            m_amplitude_level <= (it.kind == sbnep_pkg::EV_NOTE_ON) ?
                                 sbnep_pkg::amp_lookup(it.vel) : 16'd0;
            m_frequency_hz    <= (it.kind == sbnep_pkg::EV_NOTE_ON) ?
                                 sbnep_pkg::freq_lookup(it.note) : 22'd0;
            m_delay_ms        <= '0;
        end else if (st_reg == sbnep_pkg::BK_DIV && cnt_reg == 5'd0) begin
            m_event_kind      <= sbnep_pkg::EV_DELAY;
            m_voice_channel   <= '0;
            m_note_number     <= '0;
            m_amplitude_level <= '0;
            m_frequency_hz    <= '0;
            m_delay_ms        <= quo_reg;
        end
    end

    always_comb begin
        st_next  = st_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        load     = 1'b0;
        finish   = 1'b0;
        q_pop    = 1'b0;
        hold     = m_valid && !m_ready;
        unique case (st_reg)
            sbnep_pkg::BK_IDLE: begin
                if (q_valid && !hold) begin
                    load  = 1'b1;
                    q_pop = 1'b1;
                    if (it.kind == sbnep_pkg::EV_DELAY) begin
                        quo_next = {it.ticks, 8'd0};
                        rem_next = '0;
                        cnt_next = 5'd23;
                        st_next  = sbnep_pkg::BK_DIV;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            sbnep_pkg::BK_DIV: begin
                if (cnt_reg != 5'd0) begin
                    // One restoring-division step per cycle.
                    if (!trial[16]) begin
                        rem_next = trial[15:0];
                        quo_next = {quo_reg[21:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[14:0], quo_reg[22]};
                        quo_next = {quo_reg[21:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 5'd1;
                end else if (!hold) begin
                    finish  = quo_reg != 23'd0;
                    st_next = sbnep_pkg::BK_IDLE;
                end
            end
            default: st_next = sbnep_pkg::BK_IDLE;
        endcase
    end

endmodule
